### rtl/core/id_allocator_bitmap_tree_macros.svh
// ---------------------------------------------------------------------------
// id_allocator_bitmap_tree_macros
// Assertion macros of the id allocator checker.
// ---------------------------------------------------------------------------
`ifndef ID_ALLOCATOR_BITMAP_TREE_MACROS_SVH
`define ID_ALLOCATOR_BITMAP_TREE_MACROS_SVH

// clocked on clk, off while rst_n is low
`define IDA_ASSERT(lbl, pe) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) pe) \
        else $error("id allocator check failed");

`define IDA_ASSERT_MSG(lbl, pe, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) pe) \
        else $error(msg);

`endif

### rtl/core/ida_pkg.sv
// ---------------------------------------------------------------------------
// ida_pkg
// Types and constants of the bitmap id allocator.
// ---------------------------------------------------------------------------
`default_nettype none

package ida_pkg;

    localparam int FUNC_W      = 2;
    localparam int ID_W        = 31;
    localparam int LIMIT_W     = 32;
    localparam int HANDLE_IO_W = 32;
    localparam int SCAN_BITS   = 32;
    localparam int SCAN_SH     = 5;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD    = 2'd0,
        FUNC_LOOKUP = 2'd1,
        FUNC_REMOVE = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef struct packed {
        logic clr;
        logic load;
        logic div;
        logic rd;
        logic eval;
        logic scan;
        logic rd2;
        logic eval2;
        logic fid;
        logic commit;
        logic push;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic bad;
        logic is_add;
        logic word_hit;
        logic scan_hit;
        logic scan_last;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

### rtl/core/ida_ram.sv
// ---------------------------------------------------------------------------
// ida_ram
// Simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module ida_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### rtl/core/ida_ctrl.sv
// ---------------------------------------------------------------------------
// ida_ctrl
// Sequencer of the id allocator: clear pass, decode, scan and commit steps.
// ---------------------------------------------------------------------------
`default_nettype none

module ida_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire ida_pkg::status_t st,
    output ida_pkg::cmd_t        cmd
);

    typedef enum logic [3:0] {
        ST_CLR,
        ST_IDLE,
        ST_DIV,
        ST_RD,
        ST_EVAL,
        ST_SCAN,
        ST_RD2,
        ST_EVAL2,
        ST_FID,
        ST_COMMIT,
        ST_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLR:
            begin
                cmd.clr = 1'b1;
                if (st.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid && ready_reg)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div    = 1'b1;
                state_next = st.bad ? ST_FIN : ST_RD;
            end
            ST_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                cmd.eval = 1'b1;
                if (!st.is_add)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    state_next = st.word_hit ? ST_FID : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (st.scan_hit)
                begin
                    state_next = ST_RD2;
                end
                else if (st.scan_last)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_RD2:
            begin
                cmd.rd2    = 1'b1;
                state_next = ST_EVAL2;
            end
            ST_EVAL2:
            begin
                cmd.eval2  = 1'b1;
                state_next = ST_FID;
            end
            ST_FID:
            begin
                cmd.fid    = 1'b1;
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (st.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLR;
            ready_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= (state_next == ST_IDLE);
        end
    end

    assign in_ready = ready_reg;

endmodule

`default_nettype wire

### rtl/core/ida_dp.sv
// ---------------------------------------------------------------------------
// ida_dp
// Datapath: bitmap and handle RAMs, full summary, word scan, result regs.
// ---------------------------------------------------------------------------
`default_nettype none

module ida_dp #(
    parameter int ID_COUNT     = 1024,
    parameter int WORD_BITS    = 32,
    parameter int HANDLE_WIDTH = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire ida_pkg::cmd_t                 cmd,
    output ida_pkg::status_t                   st,
    input  wire logic [ida_pkg::FUNC_W-1:0]    in_func,
    input  wire logic [ida_pkg::ID_W-1:0]      in_id,
    input  wire logic [ida_pkg::LIMIT_W-1:0]   in_limit,
    input  wire logic [ida_pkg::HANDLE_IO_W-1:0] in_handle,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               out_ok,
    output logic [ida_pkg::ID_W-1:0]           out_id,
    output logic [ida_pkg::HANDLE_IO_W-1:0]    out_handle
);

    localparam int NWORDS    = (ID_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int IDW       = $clog2(ID_COUNT);
    localparam int WAW       = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int BW        = $clog2(WORD_BITS);
    localparam int NCH       = (NWORDS + ida_pkg::SCAN_BITS - 1) / ida_pkg::SCAN_BITS;
    localparam int CW        = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int XW        = CW + ida_pkg::SCAN_SH;
    localparam int LAST_BITS = ID_COUNT - (NWORDS - 1) * WORD_BITS;
    localparam int SHIFT     = IDW + BW;
    localparam int RW        = IDW + 2;
    localparam longint RECIP = ((longint'(1) << SHIFT) + WORD_BITS - 1) / WORD_BITS;
    localparam logic [WORD_BITS-1:0] ALL_ONES  = {WORD_BITS{1'b1}};
    localparam logic [WORD_BITS-1:0] LAST_MASK = ALL_ONES >> (WORD_BITS - LAST_BITS);
    localparam logic [RW-1:0] RECIP_C = RW'(RECIP);

    function automatic logic [BW-1:0] ffs_word(input logic [WORD_BITS-1:0] v);
        logic [BW-1:0] r;
        r = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = BW'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [ida_pkg::SCAN_SH-1:0] ffs_chunk(
        input logic [ida_pkg::SCAN_BITS-1:0] v);
        logic [ida_pkg::SCAN_SH-1:0] r;
        r = '0;
        for (int i = ida_pkg::SCAN_BITS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = ida_pkg::SCAN_SH'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [WORD_BITS-1:0] valid_mask(input logic [WAW-1:0] w);
        return (w == WAW'(NWORDS - 1)) ? LAST_MASK : ALL_ONES;
    endfunction

    ida_pkg::func_t                   func_reg;
    logic [IDW-1:0]                   id_reg;
    logic                             inrange_reg;
    logic [ida_pkg::LIMIT_W-1:0]      limit_reg;
    logic [HANDLE_WIDTH-1:0]          handle_reg;
    logic [WAW-1:0]                   w_reg;
    logic [BW-1:0]                    b_reg;
    logic [WORD_BITS-1:0]             word_reg;
    logic [WAW-1:0]                   fw_reg;
    logic [BW-1:0]                    fb_reg;
    logic [IDW-1:0]                   fid_reg;
    logic [WAW-1:0]                   clr_cnt_reg;
    logic [CW-1:0]                    scan_c_reg;
    logic [NWORDS-1:0]                sum_reg;
    logic                             res_ok_reg;
    logic [ida_pkg::ID_W-1:0]         res_id_reg;
    logic [ida_pkg::HANDLE_IO_W-1:0]  res_h_reg;
    logic                             out_valid_reg;
    logic                             out_ok_reg;
    logic [ida_pkg::ID_W-1:0]         out_id_reg;
    logic [ida_pkg::HANDLE_IO_W-1:0]  out_h_reg;

    logic [WORD_BITS-1:0]             bm_rdata;
    logic [HANDLE_WIDTH-1:0]          hs_rdata;
    logic                             bm_we;
    logic [WAW-1:0]                   bm_waddr;
    logic [WORD_BITS-1:0]             bm_wdata;
    logic [WAW-1:0]                   bm_raddr;
    logic                             hs_we;
    logic [IDW+RW-1:0]                quot_prod;
    logic [IDW-1:0]                   b_diff;
    logic [WORD_BITS-1:0]             bit_b;
    logic [WORD_BITS-1:0]             bit_fb;
    logic [WORD_BITS-1:0]             free_first;
    logic [WORD_BITS-1:0]             new_word;
    logic                             id_bit;
    logic                             lim_ok;
    logic [NCH*ida_pkg::SCAN_BITS-1:0] sum_pad;
    logic [ida_pkg::SCAN_BITS-1:0]    chunk;
    logic [ida_pkg::SCAN_BITS-1:0]    cand;
    logic [XW-1:0]                    hit_idx;

    assign quot_prod  = IDW'(id_reg) * RECIP_C;
    assign b_diff     = id_reg - IDW'(w_reg * WORD_BITS);
    assign bit_b      = WORD_BITS'(1) << b_reg;
    assign bit_fb     = WORD_BITS'(1) << fb_reg;
    assign free_first = ~bm_rdata & valid_mask(w_reg) & (ALL_ONES << b_reg);
    assign id_bit     = |(bm_rdata & bit_b);
    assign new_word   = word_reg | bit_fb;
    assign lim_ok     = !limit_reg[ida_pkg::LIMIT_W-1]
                        && (ida_pkg::LIMIT_W'(fid_reg) <= limit_reg);

    assign sum_pad = {{(NCH*ida_pkg::SCAN_BITS - NWORDS){1'b1}}, sum_reg};
    assign chunk   = sum_pad[scan_c_reg*ida_pkg::SCAN_BITS +: ida_pkg::SCAN_BITS];

    always_comb
    begin
        for (int j = 0; j < ida_pkg::SCAN_BITS; j++)
        begin
            cand[j] = !chunk[j]
                      && ({scan_c_reg, ida_pkg::SCAN_SH'(j)} > XW'(w_reg));
        end
    end

    assign hit_idx = {scan_c_reg, ffs_chunk(cand)};

    always_comb
    begin
        bm_we    = 1'b0;
        bm_waddr = w_reg;
        bm_wdata = '0;
        if (cmd.clr)
        begin
            bm_we    = 1'b1;
            bm_waddr = clr_cnt_reg;
        end
        else if (cmd.eval && func_reg == ida_pkg::FUNC_REMOVE && id_bit)
        begin
            bm_we    = 1'b1;
            bm_wdata = bm_rdata & ~bit_b;
        end
        else if (cmd.commit && lim_ok)
        begin
            bm_we    = 1'b1;
            bm_waddr = fw_reg;
            bm_wdata = new_word;
        end
    end

    assign bm_raddr = cmd.rd2 ? fw_reg : w_reg;
    assign hs_we    = cmd.commit && lim_ok;

    ida_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NWORDS)
    ) u_bitmap (
        .clk   (clk),
        .we    (bm_we),
        .waddr (bm_waddr),
        .wdata (bm_wdata),
        .raddr (bm_raddr),
        .rdata (bm_rdata)
    );

    ida_ram #(
        .WIDTH (HANDLE_WIDTH),
        .DEPTH (ID_COUNT)
    ) u_handles (
        .clk   (clk),
        .we    (hs_we),
        .waddr (fid_reg),
        .wdata (handle_reg),
        .raddr (id_reg),
        .rdata (hs_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg    <= ida_pkg::func_t'(in_func);
            id_reg      <= IDW'(in_id);
            inrange_reg <= (in_id < ida_pkg::ID_W'(ID_COUNT));
            limit_reg   <= in_limit;
            handle_reg  <= HANDLE_WIDTH'(in_handle);
        end
        if (cmd.div)
        begin
            w_reg      <= quot_prod[SHIFT +: WAW];
            res_ok_reg <= 1'b0;
            res_id_reg <= '0;
            res_h_reg  <= '0;
        end
        if (cmd.rd)
        begin
            b_reg <= b_diff[BW-1:0];
        end
        if (cmd.eval)
        begin
            word_reg   <= bm_rdata;
            fw_reg     <= w_reg;
            fb_reg     <= ffs_word(free_first);
            scan_c_reg <= CW'(w_reg >> ida_pkg::SCAN_SH);
            if (func_reg == ida_pkg::FUNC_LOOKUP)
            begin
                res_ok_reg <= id_bit;
                res_h_reg  <= id_bit ? ida_pkg::HANDLE_IO_W'(hs_rdata) : '0;
            end
            else if (func_reg == ida_pkg::FUNC_REMOVE)
            begin
                res_ok_reg <= id_bit;
            end
        end
        if (cmd.scan)
        begin
            if (|cand)
            begin
                fw_reg <= WAW'(hit_idx);
            end
            else
            begin
                scan_c_reg <= scan_c_reg + CW'(1);
            end
        end
        if (cmd.eval2)
        begin
            word_reg <= bm_rdata;
            fb_reg   <= ffs_word(~bm_rdata & valid_mask(fw_reg));
        end
        if (cmd.fid)
        begin
            fid_reg <= IDW'(fw_reg * WORD_BITS) + IDW'(fb_reg);
        end
        if (cmd.commit && lim_ok)
        begin
            res_ok_reg <= 1'b1;
            res_id_reg <= ida_pkg::ID_W'(fid_reg);
        end
        if (cmd.push)
        begin
            out_ok_reg <= res_ok_reg;
            out_id_reg <= res_id_reg;
            out_h_reg  <= res_h_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr)
            begin
                clr_cnt_reg <= clr_cnt_reg + WAW'(1);
            end
            if (cmd.eval && func_reg == ida_pkg::FUNC_REMOVE && id_bit)
            begin
                sum_reg[w_reg] <= 1'b0;
            end
            if (cmd.commit && lim_ok)
            begin
                sum_reg[fw_reg] <= ((new_word & valid_mask(fw_reg)) == valid_mask(fw_reg));
            end
            if (cmd.push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        st.clr_last  = (clr_cnt_reg == WAW'(NWORDS - 1));
        st.bad       = (func_reg == ida_pkg::FUNC_NONE) || !inrange_reg;
        st.is_add    = (func_reg == ida_pkg::FUNC_ADD);
        st.word_hit  = |free_first;
        st.scan_hit  = |cand;
        st.scan_last = (scan_c_reg == CW'(NCH - 1));
        st.out_free  = !out_valid_reg || out_ready;
    end

    assign out_valid  = out_valid_reg;
    assign out_ok     = out_ok_reg;
    assign out_id     = out_id_reg;
    assign out_handle = out_h_reg;

endmodule

`default_nettype wire

### rtl/core/id_allocator_bitmap_tree.sv
// ---------------------------------------------------------------------------
// id_allocator_bitmap_tree
// Id allocator over a two-level bitmap: add, lookup and remove requests.
// ---------------------------------------------------------------------------
// Usage:
//   Request beats enter on s_*: s_tuser carries the operation (add, lookup,
//   remove), s_tdata the start/target id, the limit and the handle.
//   Each request gives one result beat on m_*: m_tuser is the ok flag,
//   m_tdata the allocated id and the looked-up handle.
//   One request is worked on at a time. Lookup and remove read the bitmap
//   word of the id; an unused operation or an id beyond ID_COUNT goes
//   straight to the result. An add looks first in its start word, from the
//   start id on; if no id is free there it walks the summary in 32-word
//   chunks (at most ceil(ID_COUNT/WORD_BITS/32) of them). The next request
//   can be taken once its result is registered. The summary scan and the
//   single read port of the bitmap RAM set how long a request takes.
//   The result sits in an output register; s_tready returns while it
//   waits, and a stalled m_tready holds the next result inside the block.
//   After reset the bitmap RAM is cleared one word per cycle, all
//   ceil(ID_COUNT/WORD_BITS) words, with s_tready low.
//   A lookup of an id that is not allocated returns a zero handle, ok low.
// ---------------------------------------------------------------------------
`default_nettype none

module id_allocator_bitmap_tree #(
    parameter int ID_COUNT     = 1024,
    parameter int WORD_BITS    = 32,
    parameter int HANDLE_WIDTH = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [95:0] s_tdata,   // id[30:0], limit[62:31], handle[94:63], pad
    input  wire logic [1:0]  s_tuser,   // func[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // id_out[30:0], handle_out[62:31], pad
    output logic             m_tuser    // ok
);

    ida_pkg::cmd_t    cmd;
    ida_pkg::status_t st;
    logic [ida_pkg::ID_W-1:0]        out_id;
    logic [ida_pkg::HANDLE_IO_W-1:0] out_handle;

    ida_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    ida_dp #(
        .ID_COUNT     (ID_COUNT),
        .WORD_BITS    (WORD_BITS),
        .HANDLE_WIDTH (HANDLE_WIDTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .st         (st),
        .in_func    (s_tuser),
        .in_id      (s_tdata[30:0]),
        .in_limit   (s_tdata[62:31]),
        .in_handle  (s_tdata[94:63]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_ok     (m_tuser),
        .out_id     (out_id),
        .out_handle (out_handle)
    );

    assign m_tdata = {1'b0, out_handle, out_id};

endmodule

`default_nettype wire

### rtl/core/ida_checker.sv
// ---------------------------------------------------------------------------
// ida_checker
// Port-level checks of the id allocator, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "id_allocator_bitmap_tree_macros.svh"

module ida_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [63:0] m_tdata,
    input wire logic        m_tuser
);

    `IDA_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    `IDA_ASSERT_MSG(a_fail_zero, m_tvalid && !m_tuser |-> m_tdata == 64'd0, "failed result not zero")
    `IDA_ASSERT_MSG(a_id_or_handle, m_tvalid && m_tdata[30:0] != 31'd0 |-> m_tdata[62:31] == 32'd0, "id and handle both set")
    `IDA_ASSERT_MSG(a_busy_after_accept, s_tvalid && s_tready |=> !s_tready, "accepted beats back to back")

endmodule

bind id_allocator_bitmap_tree ida_checker u_ida_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
